// ----- rtl/mono_lcd_framebuffer_scanout_defines.svh -----
// Assertion macros for the monochrome frame store scan-out block.
// Included by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef MONO_LCD_FRAMEBUFFER_SCANOUT_DEFINES_SVH
`define MONO_LCD_FRAMEBUFFER_SCANOUT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on aclk, off while in reset
`define MLFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mlfs assertion failed");
// Next-cycle implication, sampled on aclk, off while in reset
`define MLFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mlfs assertion failed");
`else
`define MLFS_ASSERT_IMP(lbl, ante, cons)
`define MLFS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/mlfs_pkg.sv -----
// Shared constants, codes and control types of the frame store scan-out block.
// No dependencies; used by every module of the block except mlfs_ram.
package mlfs_pkg;

    // Panel geometry
    localparam int PANEL_WIDTH  = 84;
    localparam int PANEL_HEIGHT = 48;
    localparam int PAGE_COUNT   = 6;
    localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;

    // Widths
    localparam int COORD_W = 8;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int STEP_W  = $clog2(PANEL_WIDTH + 3);
    localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ROW_W   = 3;  // rows per page = 2**ROW_W
    localparam int PAGE_SEL_W = COORD_W - ROW_W;  // row bits above the in-page row

    // Panel command bytes
    localparam logic [BYTE_W-1:0] CMD_Y_ADDR = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_X_ADDR = 8'h80;

    typedef enum logic [1:0] {
        ACT_SET_PIXEL = 2'd0,
        ACT_CLEAR     = 2'd1,
        ACT_START     = 2'd2,
        ACT_TICK      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_WR,
        ST_TICK_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic pix_rd;      // latch pixel write, read its byte
        logic pix_wr;      // write modified byte back
        logic clr_start;   // restart clear sweep
        logic clr_wr;      // clear one byte, advance sweep
        logic scan_start;  // start refresh from page 0
        logic tick_rd;     // latch next panel byte, advance scan
        logic out_load;    // move pending byte into output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pix_in_range;
        logic scan_active;
        logic out_free;
        logic clr_last;
    } sts_t;

endpackage

// ----- rtl/mlfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mlfs_datapath.sv -----
// Datapath: frame store RAM, pixel read-modify-write, clear sweep, scan counters
// and the output register. Depends on mlfs_pkg and mlfs_ram.
module mlfs_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mlfs_pkg::cmd_t                cmd,
    output mlfs_pkg::sts_t                sts,
    input  logic [mlfs_pkg::COORD_W-1:0]  pixel_x,
    input  logic [mlfs_pkg::COORD_W-1:0]  pixel_y,
    input  logic                          pixel_on,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_is_data,
    output logic [mlfs_pkg::BYTE_W-1:0]   out_byte,
    output logic                          out_last
);

    logic [mlfs_pkg::PAGE_SEL_W-1:0] pix_page;
    logic [mlfs_pkg::ADDR_W-1:0]     pix_addr;
    logic [mlfs_pkg::BYTE_W-1:0]     pix_mask;
    logic [mlfs_pkg::ADDR_W-1:0]     pix_addr_reg;
    logic [mlfs_pkg::BYTE_W-1:0]     pix_mask_reg;
    logic                            pix_on_reg;
    logic [mlfs_pkg::BYTE_W-1:0]     pix_wdata;

    logic [mlfs_pkg::ADDR_W-1:0]     clr_addr_reg, clr_addr_next;

    logic                            active_reg, active_next;
    logic [mlfs_pkg::PAGE_W-1:0]     page_reg, page_next;
    logic [mlfs_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [mlfs_pkg::STEP_W-1:0]     step_inc;
    logic [mlfs_pkg::ADDR_W-1:0]     scan_addr;

    logic                            pend_is_data_reg;
    logic [mlfs_pkg::BYTE_W-1:0]     pend_cmd_reg;
    logic                            pend_last_reg;
    logic                            pend_is_data_next;
    logic [mlfs_pkg::BYTE_W-1:0]     pend_cmd_next;
    logic                            pend_last_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            out_is_data_reg;
    logic [mlfs_pkg::BYTE_W-1:0]     out_byte_reg;
    logic                            out_last_reg;

    logic                            ram_we, ram_re;
    logic [mlfs_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [mlfs_pkg::BYTE_W-1:0]     ram_wdata, ram_rdata;

    // Pixel address and range check
    assign pix_page = pixel_y[mlfs_pkg::COORD_W-1:mlfs_pkg::ROW_W];
    assign pix_addr = mlfs_pkg::ADDR_W'(pix_page) * mlfs_pkg::ADDR_W'(mlfs_pkg::PANEL_WIDTH)
                    + mlfs_pkg::ADDR_W'(pixel_x);
    assign pix_mask = mlfs_pkg::BYTE_W'(1) << pixel_y[mlfs_pkg::ROW_W-1:0];

    assign sts.pix_in_range = (pixel_x < mlfs_pkg::COORD_W'(mlfs_pkg::PANEL_WIDTH))
                           && (pixel_y < mlfs_pkg::COORD_W'(mlfs_pkg::PANEL_HEIGHT))
                           && (pix_page < mlfs_pkg::PAGE_SEL_W'(mlfs_pkg::PAGE_COUNT));

    always_ff @(posedge aclk) begin
        if (cmd.pix_rd) begin
            pix_addr_reg <= pix_addr;
            pix_mask_reg <= pix_mask;
            pix_on_reg   <= pixel_on;
        end
    end

    assign pix_wdata = pix_on_reg ? (ram_rdata | pix_mask_reg) : (ram_rdata & ~pix_mask_reg);

    // Clear sweep counter
    always_comb begin
        clr_addr_next = clr_addr_reg;
        if (cmd.clr_start) begin
            clr_addr_next = '0;
        end else if (cmd.clr_wr) begin
            clr_addr_next = clr_addr_reg + mlfs_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign sts.clr_last = (clr_addr_reg == mlfs_pkg::ADDR_W'(mlfs_pkg::STORE_BYTES - 1));

    // Scan sequencing: Y command, X command, data bytes per page, final Y command
    assign step_inc  = step_reg + mlfs_pkg::STEP_W'(1);
    assign scan_addr = mlfs_pkg::ADDR_W'(page_reg) * mlfs_pkg::ADDR_W'(mlfs_pkg::PANEL_WIDTH)
                     + mlfs_pkg::ADDR_W'(step_reg - mlfs_pkg::STEP_W'(2));

    always_comb begin
        active_next       = active_reg;
        page_next         = page_reg;
        step_next         = step_reg;
        pend_is_data_next = pend_is_data_reg;
        pend_cmd_next     = pend_cmd_reg;
        pend_last_next    = pend_last_reg;
        if (cmd.scan_start) begin
            active_next = 1'b1;
            page_next   = '0;
            step_next   = '0;
        end else if (cmd.tick_rd) begin
            pend_is_data_next = 1'b0;
            pend_last_next    = 1'b0;
            priority if (step_reg == '0) begin
                pend_cmd_next = mlfs_pkg::CMD_Y_ADDR | mlfs_pkg::BYTE_W'(page_reg);
                step_next     = step_inc;
            end else if (step_reg == mlfs_pkg::STEP_W'(1)) begin
                pend_cmd_next = mlfs_pkg::CMD_X_ADDR;
                step_next     = step_inc;
            end else if (step_reg < mlfs_pkg::STEP_W'(mlfs_pkg::PANEL_WIDTH + 2)) begin
                pend_is_data_next = 1'b1;
                step_next         = step_inc;
                if (step_inc == mlfs_pkg::STEP_W'(mlfs_pkg::PANEL_WIDTH + 2)
                        && page_reg != mlfs_pkg::PAGE_W'(mlfs_pkg::PAGE_COUNT - 1)) begin
                    page_next = page_reg + mlfs_pkg::PAGE_W'(1);
                    step_next = '0;
                end
            end else begin
                pend_cmd_next  = mlfs_pkg::CMD_Y_ADDR;
                pend_last_next = 1'b1;
                active_next    = 1'b0;
                page_next      = '0;
                step_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            page_reg   <= '0;
            step_reg   <= '0;
        end else begin
            active_reg <= active_next;
            page_reg   <= page_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_is_data_reg <= pend_is_data_next;
        pend_cmd_reg     <= pend_cmd_next;
        pend_last_reg    <= pend_last_next;
    end

    assign sts.scan_active = active_reg;

    // Frame store
    assign ram_we    = cmd.pix_wr | cmd.clr_wr;
    assign ram_waddr = cmd.clr_wr ? clr_addr_reg : pix_addr_reg;
    assign ram_wdata = cmd.clr_wr ? '0 : pix_wdata;
    assign ram_re    = cmd.pix_rd | cmd.tick_rd;
    assign ram_raddr = cmd.pix_rd ? pix_addr : scan_addr;

    mlfs_ram #(
        .WIDTH (mlfs_pkg::BYTE_W),
        .DEPTH (mlfs_pkg::STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_is_data_reg <= pend_is_data_reg;
            out_byte_reg    <= pend_is_data_reg ? ram_rdata : pend_cmd_reg;
            out_last_reg    <= pend_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_is_data = out_is_data_reg;
    assign out_byte    = out_byte_reg;
    assign out_last    = out_last_reg;

endmodule

// ----- rtl/mlfs_ctrl.sv -----
// Controller state machine: accepts items, sequences the clear sweep, pixel
// read-modify-write and scan ticks. Depends on mlfs_pkg.
module mlfs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  mlfs_pkg::action_t action,
    input  mlfs_pkg::sts_t    sts,
    output mlfs_pkg::cmd_t    cmd
);

    mlfs_pkg::state_t state_reg, state_next;

    // State register; reset starts with a clear sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlfs_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mlfs_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = mlfs_pkg::ST_IDLE;
                end
            end
            mlfs_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    unique case (action)
                        mlfs_pkg::ACT_SET_PIXEL: begin
                            if (sts.pix_in_range) begin
                                cmd.pix_rd = 1'b1;
                                state_next = mlfs_pkg::ST_PIX_WR;
                            end
                        end
                        mlfs_pkg::ACT_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            state_next    = mlfs_pkg::ST_CLEAR;
                        end
                        mlfs_pkg::ACT_START: begin
                            cmd.scan_start = 1'b1;
                        end
                        mlfs_pkg::ACT_TICK: begin
                            if (sts.scan_active) begin
                                cmd.tick_rd = 1'b1;
                                state_next  = mlfs_pkg::ST_TICK_OUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mlfs_pkg::ST_PIX_WR: begin
                cmd.pix_wr = 1'b1;
                state_next = mlfs_pkg::ST_IDLE;
            end
            mlfs_pkg::ST_TICK_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = mlfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mlfs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/mono_lcd_framebuffer_scanout.sv -----
// Top level of the monochrome panel frame store with byte-wise scan-out.
// Depends on mlfs_pkg, mlfs_ctrl, mlfs_datapath and the assertion macro header.
//
// An 84 by 48 pixel page-organised frame store (8 rows per byte) in one RAM
// with one write and one registered read port. Input items set or clear a
// pixel, clear the store, start a refresh or tick the scan; a tick during a
// refresh returns one panel byte (per page a Y command, an X command of
// column 0, 84 data bytes; then a final Y-zero command with tlast). Item cost
// is set by the registered RAM read: a start and a tick while idle need no
// read, a pixel write reads its byte, then writes it back (no access when the
// pixel is off the panel), a tick during a refresh reads its byte, then waits
// for the output register to drain, and a store clear sweeps the store one
// byte per cycle. After reset the store is swept to zero, during which s_tready
// stays low.
`include "mono_lcd_framebuffer_scanout_defines.svh"

module mono_lcd_framebuffer_scanout (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [16] pixel_on, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] panel_byte
    output logic        m_tuser,   // [0] is_data
    output logic        m_tlast    // frame_last
);

    mlfs_pkg::cmd_t    cmd;
    mlfs_pkg::sts_t    sts;
    mlfs_pkg::action_t action;

    assign action = mlfs_pkg::action_t'(s_tuser);

    mlfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd)
    );

    mlfs_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .pixel_x     (s_tdata[7:0]),
        .pixel_y     (s_tdata[15:8]),
        .pixel_on    (s_tdata[16]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_is_data (m_tuser),
        .out_byte    (m_tdata),
        .out_last    (m_tlast)
    );

    // A pending byte is never loaded over an undelivered one
    `MLFS_ASSERT_IMP(a_load_free, cmd.out_load, sts.out_free)
    // After a tick is taken no item is accepted until its byte is loaded
    `MLFS_ASSERT_NEXT(a_tick_blocks, cmd.tick_rd, !s_tready)
    // The last byte of a refresh is always a command
    `MLFS_ASSERT_IMP(a_last_is_cmd, m_tvalid && m_tlast, !m_tuser)

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the monochrome frame store scan-out block.
// Depends on mlfs_pkg and the RTL top mono_lcd_framebuffer_scanout; it reads no files.
// An in-bench model of the store and scan sequence predicts each panel byte.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected panel byte with its flags
    typedef struct packed {
        bit       is_data;
        bit [7:0] panel_byte;
        bit       frame_last;
    } panel_out_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [7:0] pixel_x, [15:8] pixel_y, [16] pixel_on, rest zero
    logic [1:0]  s_tuser  = '0;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] panel_byte
    logic        m_tuser;         // [0] is_data
    logic        m_tlast;

    // Model state: frame store and scan position
    bit [7:0]   model_store [mlfs_pkg::STORE_BYTES];
    bit         scan_busy;
    int         scan_page;
    int         scan_step;
    panel_out_t expected_bytes [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    bit tx_gaps        = 1'b0;
    bit rx_gaps        = 1'b0;
    int hold_request   = 0;

    mono_lcd_framebuffer_scanout u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Apply one accepted item to the model, queue the panel byte it yields
    function automatic void predict_item(mlfs_pkg::action_t act, bit [7:0] x, bit [7:0] y,
                                         bit on);
        int idx;
        idx = int'(y >> 3) * mlfs_pkg::PANEL_WIDTH + int'(x);
        case (act)
            mlfs_pkg::ACT_SET_PIXEL: begin
                // out-of-range pixels are dropped
                if (x < mlfs_pkg::PANEL_WIDTH && y < mlfs_pkg::PANEL_HEIGHT
                        && int'(y >> 3) < mlfs_pkg::PAGE_COUNT)
                    model_store[idx][y[2:0]] = on;
            end
            mlfs_pkg::ACT_CLEAR: begin
                foreach (model_store[i]) model_store[i] = '0;
            end
            mlfs_pkg::ACT_START: begin
                scan_busy = 1'b1;
                scan_page = 0;
                scan_step = 0;
            end
            mlfs_pkg::ACT_TICK: begin
                // tick while idle yields nothing
                if (scan_busy) begin
                    if (scan_step == 0) begin
                        expected_bytes.push_back({1'b0,
                            mlfs_pkg::CMD_Y_ADDR | 8'(scan_page), 1'b0});
                        scan_step = 1;
                    end else if (scan_step == 1) begin
                        expected_bytes.push_back({1'b0, mlfs_pkg::CMD_X_ADDR, 1'b0});
                        scan_step = 2;
                    end else if (scan_step < mlfs_pkg::PANEL_WIDTH + 2) begin
                        expected_bytes.push_back({1'b1,
                            model_store[scan_page * mlfs_pkg::PANEL_WIDTH + scan_step - 2],
                            1'b0});
                        scan_step++;
                        if (scan_step == mlfs_pkg::PANEL_WIDTH + 2
                                && scan_page + 1 < mlfs_pkg::PAGE_COUNT) begin
                            scan_page++;
                            scan_step = 0;
                        end
                    end else begin
                        // closing Y-zero command ends the refresh
                        expected_bytes.push_back({1'b0, mlfs_pkg::CMD_Y_ADDR, 1'b1});
                        scan_busy = 1'b0;
                        scan_page = 0;
                        scan_step = 0;
                    end
                end
            end
        endcase
    endfunction

    // Offer one item, wait for acceptance, predict, maybe idle afterwards
    task automatic send_item(input mlfs_pkg::action_t act, input bit [7:0] x,
                             input bit [7:0] y, input bit on);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, on, y, x};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        predict_item(act, x, y, on);
        items_sent++;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // Non-pixel item with random ignored fields
    task automatic send_action(input mlfs_pkg::action_t act);
        send_item(act, 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Mostly in-range coordinate, sometimes anything
    function automatic bit [7:0] pick_coord(int limit);
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, limit - 1));
    endfunction

    // Receiver: ready with random stall bursts, plus a long hold on request
    initial begin : result_sink
        int hold_len;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_len = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted panel byte against the oldest prediction
    always @(posedge aclk) begin : check_results
        panel_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected item, expected none, got data=%0b byte=%02h last=%0b",
                         $time, m_tuser, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_tuser !== want.is_data) begin
                    $display("%0t: is_data expected %0b got %0b", $time, want.is_data, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata !== want.panel_byte) begin
                    $display("%0t: panel_byte expected %02h got %02h",
                             $time, want.panel_byte, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.frame_last) begin
                    $display("%0t: frame_last expected %0b got %0b",
                             $time, want.frame_last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Corners of the panel, points outside it, and an inner pixel set then cleared
    task automatic test_pixel_extremes();
        send_item(mlfs_pkg::ACT_SET_PIXEL, 8'd0,   8'd0,   1'b1);
        send_item(mlfs_pkg::ACT_SET_PIXEL, 8'd83,  8'd47,  1'b1);
        send_item(mlfs_pkg::ACT_SET_PIXEL, 8'd83,  8'd0,   1'b1);
        send_item(mlfs_pkg::ACT_SET_PIXEL, 8'd0,   8'd47,  1'b1);
        send_item(mlfs_pkg::ACT_SET_PIXEL, 8'd84,  8'd5,   1'b1);
        send_item(mlfs_pkg::ACT_SET_PIXEL, 8'd10,  8'd48,  1'b1);
        send_item(mlfs_pkg::ACT_SET_PIXEL, 8'd255, 8'd255, 1'b1);
        send_item(mlfs_pkg::ACT_SET_PIXEL, 8'd40,  8'd20,  1'b1);
        send_item(mlfs_pkg::ACT_SET_PIXEL, 8'd40,  8'd20,  1'b0);
        send_item(mlfs_pkg::ACT_SET_PIXEL, 8'd0,   8'd0,   1'b0);
    endtask

    // Ticks with no refresh running give nothing
    task automatic test_idle_tick();
        send_action(mlfs_pkg::ACT_TICK);
        send_action(mlfs_pkg::ACT_TICK);
    endtask

    // Restart mid-refresh, pixel write and store clear while scanning
    task automatic test_refresh_restart();
        send_action(mlfs_pkg::ACT_START);
        repeat (4) send_action(mlfs_pkg::ACT_TICK);
        send_item(mlfs_pkg::ACT_SET_PIXEL, 8'd1, 8'd0, 1'b1);
        send_action(mlfs_pkg::ACT_TICK);
        send_action(mlfs_pkg::ACT_START);
        repeat (3) send_action(mlfs_pkg::ACT_TICK);
        send_action(mlfs_pkg::ACT_CLEAR);
        send_action(mlfs_pkg::ACT_TICK);
    endtask

    // Receiver holds off while ticks keep coming, so the input stalls
    task automatic test_output_backpressure();
        bit gaps_were;
        gaps_were = tx_gaps;
        tx_gaps = 1'b0;
        send_action(mlfs_pkg::ACT_START);
        hold_request = 300;
        repeat (40) send_action(mlfs_pkg::ACT_TICK);
        tx_gaps = gaps_were;
    endtask

    // Frames: optional clear, some pixels, then a full refresh with writes and noise mixed in
    task automatic test_random_frames(input int item_limit);
        bit restarted;
        int pick;
        while (items_sent < item_limit) begin
            restarted = 1'b0;
            if ($urandom_range(0, 5) == 0)
                send_action(mlfs_pkg::ACT_CLEAR);
            repeat ($urandom_range(5, 40))
                send_item(mlfs_pkg::ACT_SET_PIXEL, pick_coord(mlfs_pkg::PANEL_WIDTH),
                          pick_coord(mlfs_pkg::PANEL_HEIGHT), 1'($urandom));
            send_action(mlfs_pkg::ACT_START);
            // the frame is cut short once the item budget is used up
            while (scan_busy && items_sent < item_limit) begin
                pick = $urandom_range(0, 399);
                if (pick < 340) begin
                    send_action(mlfs_pkg::ACT_TICK);
                end else if (pick < 380) begin
                    send_item(mlfs_pkg::ACT_SET_PIXEL, pick_coord(mlfs_pkg::PANEL_WIDTH),
                              pick_coord(mlfs_pkg::PANEL_HEIGHT), 1'($urandom));
                end else if (pick < 382 && !restarted) begin
                    restarted = 1'b1;
                    send_action(mlfs_pkg::ACT_START);
                end else if (pick < 384) begin
                    send_action(mlfs_pkg::ACT_CLEAR);
                end else begin
                    send_item(mlfs_pkg::action_t'($urandom_range(0, 3)), 8'($urandom),
                              8'($urandom), 1'($urandom));
                end
            end
            // a few ticks after the frame has ended
            repeat ($urandom_range(0, 3)) send_action(mlfs_pkg::ACT_TICK);
            // some frames run with no idling at all
            if (item_limit < 1700) begin
                tx_gaps = 1'($urandom_range(0, 3) != 0);
                rx_gaps = 1'($urandom_range(0, 3) != 0);
            end
        end
    endtask

    // Main sequence
    initial begin
        foreach (model_store[i]) model_store[i] = '0;
        scan_busy = 1'b0;
        scan_page = 0;
        scan_step = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        test_pixel_extremes();
        test_idle_tick();
        test_refresh_restart();
        test_output_backpressure();
        test_random_frames(1350);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        test_random_frames(1700);

        // drain, then watch for stray results
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Timeout guard
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
